### rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DAT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("device address table check failed");

// Next-cycle implication, disabled during reset.
`define DAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("device address table check failed");

`endif

### rtl/dat_pkg.sv
// Types and constants of the device address table.
`timescale 1ns / 1ps
`default_nettype none
package dat_pkg;

   typedef enum logic [3:0] {
      CMD_UPSERT     = 4'd0,
      CMD_FIND_LONG  = 4'd1,
      CMD_FIND_SHORT = 4'd2,
      CMD_CHECK      = 4'd3,
      CMD_SET_BUSY   = 4'd4,
      CMD_RECLAIM    = 4'd5,
      CMD_CLAIM      = 4'd6,
      CMD_RELEASE    = 4'd7,
      CMD_RESET_DISC = 4'd8,
      CMD_ROUTE      = 4'd9
   } cmd_type;

   typedef enum logic [3:0] {
      KIND_NONE   = 4'b0001,
      KIND_UPSERT = 4'b0010,
      KIND_FIND   = 4'b0100,
      KIND_SLOT   = 4'b1000
   } kind_type;

   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_ACTIVE  = 2'd1;
   localparam logic [1:0] ST_LEAVING = 2'd2;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic [1:0]  state;
      logic [31:0] generation;
      logic [15:0] short_a;
      logic [63:0] long_a;
      logic        long_v;
      logic [15:0] prev_short;
      logic [15:0] disc_short;
      logic        busy;
   } slot_rec_type;

   typedef struct packed {
      kind_type    kind;
      cmd_type     cmd;
      logic [15:0] short_address;
      logic [63:0] long_address;
      logic        long_present;
      logic        include_inactive;
      logic [3:0]  slot_index;
      logic [31:0] handle_generation;
      logic        busy_value;
   } job_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  result_index;
      logic [31:0] result_generation;
      logic [1:0]  result_state;
      logic [15:0] result_short;
      logic [15:0] result_previous_short;
      logic [63:0] result_long;
      logic        result_long_valid;
      logic        outcome;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/dat_if.sv
// Channel interfaces of the device address table.
`timescale 1ns / 1ps
`default_nettype none
interface dat_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic [15:0] short_address;
   logic [63:0] long_address;
   logic        long_present;
   logic        include_inactive;
   logic [3:0]  slot_index;
   logic [31:0] handle_generation;
   logic        busy_value;
   modport source (output valid, command, short_address, long_address, long_present,
      include_inactive, slot_index, handle_generation, busy_value, input ready);
   modport sink (input valid, command, short_address, long_address, long_present,
      include_inactive, slot_index, handle_generation, busy_value, output ready);
endinterface

interface dat_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [3:0]  result_index;
   logic [31:0] result_generation;
   logic [1:0]  result_state;
   logic [15:0] result_short;
   logic [15:0] result_previous_short;
   logic [63:0] result_long;
   logic        result_long_valid;
   logic        outcome;
   modport source (output valid, found, result_index, result_generation, result_state,
      result_short, result_previous_short, result_long, result_long_valid, outcome,
      input ready);
   modport sink (input valid, found, result_index, result_generation, result_state,
      result_short, result_previous_short, result_long, result_long_valid, outcome,
      output ready);
endinterface

interface dat_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] invalid_short_addr;
   modport source (output valid, invalid_short_addr, input ready);
   modport sink (input valid, invalid_short_addr, output ready);
endinterface
`default_nettype wire

### rtl/device_address_table_core.sv
// Top level of the device address table: front end, job queue, sequencer and register.
// Per-slot commands visit one slot; a find scans the slots in order until a hit; an upsert
// scans up to three times (match, allocate, old holder) before its final write.
// One command at a time is in the sequencer, paced by the single read port of the slot
// memory; two further commands can wait in the queue.
// Reset clears the slot valid bits, so every slot reads empty; no sweep is run.
`timescale 1ns / 1ps
`default_nettype none
module device_address_table_core #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dat_req_if.sink    req_chan,
   dat_rsp_if.source  rsp_chan,
   dat_csr_if.sink    csr_chan
);
   logic [15:0]      inv_ff, inv_in;
   logic             q_full, q_push, q_pop, q_empty;
   dat_pkg::job_type q_job, q_head;

   assign csr_chan.ready = 1'b1;
   assign inv_in = csr_chan.valid ? csr_chan.invalid_short_addr : inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 16'hFFFF;
      end else begin
         inv_ff <= inv_in;
      end
   end

   dat_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   dat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   dat_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock         (clock),
      .reset         (reset),
      .invalid_short (inv_ff),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp           (rsp_chan)
   );
endmodule
`default_nettype wire

### rtl/dat_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module dat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### rtl/dat_front.sv
// Front end: takes request transfers and classifies them into jobs.
`timescale 1ns / 1ps
`default_nettype none
module dat_front #(
   parameter int SLOT_COUNT = 16
) (
   dat_req_if.sink               req,
   input  wire logic             q_full,
   output logic                  q_push,
   output dat_pkg::job_type      q_job
);
   logic in_range;

   assign in_range = {28'd0, req.slot_index} < 32'(SLOT_COUNT);
   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;

   always_comb begin
      q_job.cmd = dat_pkg::cmd_type'(req.command);
      q_job.short_address = req.short_address;
      q_job.long_address = req.long_address;
      q_job.long_present = req.long_present;
      q_job.include_inactive = req.include_inactive;
      q_job.slot_index = req.slot_index;
      q_job.handle_generation = req.handle_generation;
      q_job.busy_value = req.busy_value;
      unique case (req.command) inside
         dat_pkg::CMD_UPSERT: q_job.kind = dat_pkg::KIND_UPSERT;
         dat_pkg::CMD_FIND_LONG, dat_pkg::CMD_FIND_SHORT: q_job.kind = dat_pkg::KIND_FIND;
         dat_pkg::CMD_CHECK, dat_pkg::CMD_SET_BUSY, dat_pkg::CMD_RECLAIM,
         dat_pkg::CMD_CLAIM, dat_pkg::CMD_RELEASE, dat_pkg::CMD_RESET_DISC,
         dat_pkg::CMD_ROUTE: begin
            q_job.kind = in_range ? dat_pkg::KIND_SLOT : dat_pkg::KIND_NONE;
         end
         default: q_job.kind = dat_pkg::KIND_NONE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/dat_queue.sv
// Short job queue between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dat_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dat_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output dat_pkg::job_type      head
);
   dat_pkg::job_type             mem_ff [dat_pkg::Q_DEPTH];
   logic [dat_pkg::Q_PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [dat_pkg::Q_CNT_W-1:0]  cnt_ff, cnt_in;

   assign full = cnt_ff == dat_pkg::Q_CNT_W'(dat_pkg::Q_DEPTH);
   assign empty = cnt_ff == '0;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + dat_pkg::Q_CNT_W'(push) - dat_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### rtl/dat_back.sv
// Back end: sequencer that scans and updates the slot memory, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module dat_back #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      invalid_short,
   input  wire logic             q_empty,
   input  wire dat_pkg::job_type q_head,
   output logic                  q_pop,
   dat_rsp_if.source             rsp
);
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int REC_W = $bits(dat_pkg::slot_rec_type);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [4:0] {
      B_IDLE   = 5'b00001,
      B_ISSUE  = 5'b00010,
      B_EVAL   = 5'b00100,
      B_FINISH = 5'b01000,
      B_DONE   = 5'b10000
   } bstate_type;

   typedef enum logic [3:0] {
      PH_MATCH = 4'b0001,
      PH_ALLOC = 4'b0010,
      PH_OLD   = 4'b0100,
      PH_ONE   = 4'b1000
   } phase_type;

   bstate_type             state_ff, state_in;
   phase_type              phase_ff, phase_in;
   dat_pkg::job_type       job_ff, job_in;
   logic [IDX_W-1:0]       addr_ff, addr_in, sidx_ff, sidx_in;
   dat_pkg::slot_rec_type  rec_ff, rec_in;
   logic [SLOT_COUNT-1:0]  valid_ff, valid_in;
   dat_pkg::rsp_type       res_ff, res_in, out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   we;
   logic [IDX_W-1:0]       waddr;
   dat_pkg::slot_rec_type  wdata;
   logic [REC_W-1:0]       rdata;
   dat_pkg::slot_rec_type  rec;
   logic                   visible, last, hit;
   dat_pkg::slot_rec_type  alloc_rec, old_rec, fin_rec, one_rec;
   logic                   one_ok, one_found, one_write;

   function automatic dat_pkg::rsp_type make_rsp(dat_pkg::slot_rec_type r,
                                                 logic [IDX_W-1:0] i, logic ok);
      dat_pkg::rsp_type o;
      o.found = 1'b1;
      o.result_index = 4'(i);
      o.result_generation = r.generation;
      o.result_state = r.state;
      o.result_short = r.short_a;
      o.result_previous_short = r.prev_short;
      o.result_long = r.long_a;
      o.result_long_valid = r.long_v;
      o.outcome = ok;
      return o;
   endfunction

   dat_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   // Entries not written since reset read as all zeros, that is as empty slots.
   assign rec = valid_ff[addr_ff] ? dat_pkg::slot_rec_type'(rdata) : '0;
   assign visible = rec.state != dat_pkg::ST_EMPTY &&
      (job_ff.include_inactive || rec.state == dat_pkg::ST_ACTIVE);
   assign last = addr_ff == LAST;

   always_comb begin
      if (job_ff.kind == dat_pkg::KIND_UPSERT) begin
         if (job_ff.long_present) begin
            hit = rec.state != dat_pkg::ST_EMPTY && rec.long_v &&
               rec.long_a == job_ff.long_address;
         end else begin
            hit = rec.state == dat_pkg::ST_ACTIVE && rec.short_a == job_ff.short_address;
         end
      end else if (job_ff.cmd == dat_pkg::CMD_FIND_LONG) begin
         hit = visible && rec.long_v && rec.long_a == job_ff.long_address;
      end else begin
         hit = visible && rec.short_a == job_ff.short_address;
      end
   end

   always_comb begin
      alloc_rec.state = dat_pkg::ST_ACTIVE;
      alloc_rec.generation = (rec.generation == 32'hFFFF_FFFF) ? 32'd1
                                                               : rec.generation + 32'd1;
      alloc_rec.short_a = job_ff.short_address;
      alloc_rec.long_a = '0;
      alloc_rec.long_v = 1'b0;
      alloc_rec.prev_short = invalid_short;
      alloc_rec.disc_short = invalid_short;
      alloc_rec.busy = 1'b0;

      // The displaced holder loses its address and is reclaimed at once unless busy.
      old_rec = rec;
      old_rec.short_a = invalid_short;
      old_rec.state = dat_pkg::ST_LEAVING;
      if (!rec.busy) begin
         old_rec.long_a = '0;
         old_rec.long_v = 1'b0;
         old_rec.state = dat_pkg::ST_EMPTY;
      end

      fin_rec = rec_ff;
      fin_rec.state = dat_pkg::ST_ACTIVE;
      if (rec_ff.short_a != invalid_short && rec_ff.short_a != job_ff.short_address) begin
         fin_rec.prev_short = rec_ff.short_a;
      end
      fin_rec.short_a = job_ff.short_address;
      if (job_ff.long_present) begin
         fin_rec.long_a = job_ff.long_address;
         fin_rec.long_v = 1'b1;
      end

      one_rec = rec;
      one_ok = 1'b0;
      one_found = 1'b1;
      one_write = 1'b1;
      case (job_ff.cmd)
         dat_pkg::CMD_CHECK: begin
            one_write = 1'b0;
            one_found = visible && rec.generation == job_ff.handle_generation;
         end
         dat_pkg::CMD_SET_BUSY: one_rec.busy = job_ff.busy_value;
         dat_pkg::CMD_RECLAIM: begin
            if (rec.state == dat_pkg::ST_LEAVING && !rec.busy) begin
               one_rec.long_a = '0;
               one_rec.long_v = 1'b0;
               one_rec.short_a = invalid_short;
               one_rec.state = dat_pkg::ST_EMPTY;
               one_ok = 1'b1;
            end
         end
         dat_pkg::CMD_CLAIM: begin
            if (rec.state == dat_pkg::ST_ACTIVE && rec.short_a != invalid_short &&
                rec.disc_short != rec.short_a) begin
               one_rec.disc_short = rec.short_a;
               one_ok = 1'b1;
            end
         end
         dat_pkg::CMD_RELEASE: begin
            if (rec.disc_short == job_ff.short_address) begin
               one_rec.disc_short = invalid_short;
            end
         end
         dat_pkg::CMD_RESET_DISC: one_rec.disc_short = invalid_short;
         default: begin
            one_write = 1'b0;
            one_ok = rec.state == dat_pkg::ST_ACTIVE &&
               job_ff.short_address != invalid_short &&
               rec.short_a == job_ff.short_address;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      job_in = job_ff;
      addr_in = addr_ff;
      sidx_in = sidx_ff;
      rec_in = rec_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      valid_in = valid_ff;
      we = 1'b0;
      waddr = addr_ff;
      wdata = rec;
      q_pop = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               job_in = q_head;
               addr_in = (q_head.kind == dat_pkg::KIND_SLOT) ? IDX_W'(q_head.slot_index) : '0;
               state_in = B_ISSUE;
               unique case (q_head.kind)
                  dat_pkg::KIND_UPSERT, dat_pkg::KIND_FIND: phase_in = PH_MATCH;
                  dat_pkg::KIND_SLOT: phase_in = PH_ONE;
                  default: begin
                     res_in = '0;
                     state_in = B_DONE;
                  end
               endcase
            end
         end
         B_ISSUE: state_in = B_EVAL;
         B_EVAL: begin
            state_in = B_ISSUE;
            unique case (phase_ff)
               PH_MATCH: begin
                  if (hit) begin
                     if (job_ff.kind == dat_pkg::KIND_UPSERT) begin
                        rec_in = rec;
                        sidx_in = addr_ff;
                        phase_in = PH_OLD;
                        addr_in = '0;
                     end else begin
                        res_in = make_rsp(rec, addr_ff, 1'b0);
                        state_in = B_DONE;
                     end
                  end else if (last) begin
                     if (job_ff.kind == dat_pkg::KIND_UPSERT) begin
                        phase_in = PH_ALLOC;
                        addr_in = '0;
                     end else begin
                        res_in = '0;
                        state_in = B_DONE;
                     end
                  end else begin
                     addr_in = addr_ff + IDX_W'(1);
                  end
               end
               PH_ALLOC: begin
                  if (rec.state == dat_pkg::ST_EMPTY) begin
                     we = 1'b1;
                     wdata = alloc_rec;
                     rec_in = alloc_rec;
                     sidx_in = addr_ff;
                     phase_in = PH_OLD;
                     addr_in = '0;
                  end else if (last) begin
                     res_in = '0;
                     state_in = B_DONE;
                  end else begin
                     addr_in = addr_ff + IDX_W'(1);
                  end
               end
               PH_OLD: begin
                  if (rec.state != dat_pkg::ST_EMPTY && rec.short_a == job_ff.short_address) begin
                     if (addr_ff != sidx_ff) begin
                        we = 1'b1;
                        wdata = old_rec;
                     end
                     state_in = B_FINISH;
                  end else if (last) begin
                     state_in = B_FINISH;
                  end else begin
                     addr_in = addr_ff + IDX_W'(1);
                  end
               end
               default: begin
                  we = one_write;
                  wdata = one_rec;
                  res_in = one_found ? make_rsp(one_rec, addr_ff, one_ok) : '0;
                  state_in = B_DONE;
               end
            endcase
         end
         B_FINISH: begin
            we = 1'b1;
            waddr = sidx_ff;
            wdata = fin_rec;
            res_in = make_rsp(fin_rec, sidx_ff, 1'b0);
            state_in = B_DONE;
         end
         default: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
      endcase

      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         phase_ff <= PH_MATCH;
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff <= job_in;
      addr_ff <= addr_in;
      sidx_ff <= sidx_in;
      rec_ff <= rec_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.found = out_ff.found;
   assign rsp.result_index = out_ff.result_index;
   assign rsp.result_generation = out_ff.result_generation;
   assign rsp.result_state = out_ff.result_state;
   assign rsp.result_short = out_ff.result_short;
   assign rsp.result_previous_short = out_ff.result_previous_short;
   assign rsp.result_long = out_ff.result_long;
   assign rsp.result_long_valid = out_ff.result_long_valid;
   assign rsp.outcome = out_ff.outcome;
endmodule
`default_nettype wire

### rtl/dat_checker.sv
// Port checker of the device address table and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dat_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [3:0]  rsp_index,
   input wire logic [31:0] rsp_gen,
   input wire logic [1:0]  rsp_state,
   input wire logic [63:0] rsp_long,
   input wire logic        rsp_long_valid,
   input wire logic        rsp_outcome
);
   `DAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_index) && $stable(rsp_gen))
   `DAT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_index == 4'd0 && rsp_gen == 32'd0 && !rsp_outcome)
   `DAT_ASSERT_NOW(a_empty_no_long, clock, reset, rsp_valid && rsp_found && rsp_state == dat_pkg::ST_EMPTY, !rsp_long_valid && rsp_long == 64'd0)
   `DAT_ASSERT_NOW(a_leaving_no_short, clock, reset, rsp_valid && rsp_state == dat_pkg::ST_LEAVING, rsp_found && !rsp_outcome)
endmodule

bind device_address_table_core dat_checker u_dat_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_found      (rsp_chan.found),
   .rsp_index      (rsp_chan.result_index),
   .rsp_gen        (rsp_chan.result_generation),
   .rsp_state      (rsp_chan.result_state),
   .rsp_long       (rsp_chan.result_long),
   .rsp_long_valid (rsp_chan.result_long_valid),
   .rsp_outcome    (rsp_chan.outcome)
);
`default_nettype wire

### bench/dat_table_checker.sv
// Checker for the device address table: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
`default_nettype none
module dat_table_checker
   import dat_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   dat_req_if        req_mon,
   dat_rsp_if        rsp_mon,
   dat_csr_if        csr_mon,
   output int        error_count,
   output int        pending_count
);

   logic [15:0] no_addr;
   logic [1:0]  t_state [SLOT_COUNT];
   logic [31:0] t_gen   [SLOT_COUNT];
   logic [15:0] t_short [SLOT_COUNT];
   logic [63:0] t_long  [SLOT_COUNT];
   logic        t_lval  [SLOT_COUNT];
   logic [15:0] t_prev  [SLOT_COUNT];
   logic [15:0] t_disc  [SLOT_COUNT];
   logic        t_busy  [SLOT_COUNT];
   rsp_type     expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic bit visible(int i, bit any);
      return t_state[i] != ST_EMPTY && (any || t_state[i] == ST_ACTIVE);
   endfunction

   function automatic int lookup_short(logic [15:0] a, bit any);
      for (int i = 0; i < SLOT_COUNT; i++)
         if (visible(i, any) && t_short[i] == a) return i;
      return -1;
   endfunction

   function automatic int lookup_long(logic [63:0] a, bit any);
      for (int i = 0; i < SLOT_COUNT; i++)
         if (visible(i, any) && t_lval[i] && t_long[i] == a) return i;
      return -1;
   endfunction

   function automatic bit free_leaving(int i);
      if (t_state[i] != ST_LEAVING || t_busy[i]) return 0;
      t_long[i]  = '0;
      t_lval[i]  = 1'b0;
      t_short[i] = no_addr;
      t_state[i] = ST_EMPTY;
      return 1;
   endfunction

   function automatic int take_empty(logic [15:0] a);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (t_state[i] == ST_EMPTY) begin
            t_gen[i]   = (t_gen[i] == '1) ? 32'd1 : t_gen[i] + 32'd1;
            t_state[i] = ST_ACTIVE;
            t_short[i] = a;
            t_long[i]  = '0;
            t_lval[i]  = 1'b0;
            t_prev[i]  = no_addr;
            t_disc[i]  = no_addr;
            t_busy[i]  = 1'b0;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic int do_upsert(logic [15:0] a, bit lp, logic [63:0] la);
      int s;
      int old;
      bit ign;
      s = lp ? lookup_long(la, 1) : lookup_short(a, 0);
      if (s < 0) s = take_empty(a);
      if (s < 0) return -1;
      old = lookup_short(a, 1);
      if (old >= 0 && old != s) begin
         // The previous holder of the address is pushed out and freed if idle.
         t_short[old] = no_addr;
         t_state[old] = ST_LEAVING;
         ign = free_leaving(old);
      end
      t_state[s] = ST_ACTIVE;
      if (t_short[s] != no_addr && t_short[s] != a) t_prev[s] = t_short[s];
      t_short[s] = a;
      if (lp) begin
         t_long[s] = la;
         t_lval[s] = 1'b1;
      end
      return s;
   endfunction

   function automatic rsp_type predict_lookup();
      rsp_type r;
      int s;
      int idx;
      bit ok;
      logic [3:0] cmd;
      logic [15:0] a;
      s = -1;
      ok = 0;
      r = '0;
      cmd = req_mon.command;
      a = req_mon.short_address;
      idx = int'(req_mon.slot_index);
      case (cmd)
         CMD_UPSERT:     s = do_upsert(a, req_mon.long_present, req_mon.long_address);
         CMD_FIND_LONG:  s = lookup_long(req_mon.long_address, req_mon.include_inactive);
         CMD_FIND_SHORT: s = lookup_short(a, req_mon.include_inactive);
         CMD_CHECK: begin
            if (idx < SLOT_COUNT && t_state[idx] != ST_EMPTY &&
                  t_gen[idx] == req_mon.handle_generation &&
                  (req_mon.include_inactive || t_state[idx] == ST_ACTIVE))
               s = idx;
         end
         CMD_SET_BUSY, CMD_RECLAIM, CMD_CLAIM, CMD_RELEASE, CMD_RESET_DISC,
               CMD_ROUTE: begin
            if (idx < SLOT_COUNT) begin
               s = idx;
               case (cmd)
                  CMD_SET_BUSY: t_busy[s] = req_mon.busy_value;
                  CMD_RECLAIM:  ok = free_leaving(s);
                  CMD_CLAIM: begin
                     if (t_state[s] == ST_ACTIVE && t_short[s] != no_addr &&
                           t_disc[s] != t_short[s]) begin
                        t_disc[s] = t_short[s];
                        ok = 1;
                     end
                  end
                  CMD_RELEASE:    if (t_disc[s] == a) t_disc[s] = no_addr;
                  CMD_RESET_DISC: t_disc[s] = no_addr;
                  default: ok = t_state[s] == ST_ACTIVE && a != no_addr && t_short[s] == a;
               endcase
            end
         end
         default: ;
      endcase
      if (s >= 0) begin
         r.found                 = 1'b1;
         r.result_index          = 4'(s);
         r.result_generation     = t_gen[s];
         r.result_state          = t_state[s];
         r.result_short          = t_short[s];
         r.result_previous_short = t_prev[s];
         r.result_long           = t_long[s];
         r.result_long_valid     = t_lval[s];
         r.outcome               = ok;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         no_addr = 16'hFFFF;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            t_state[i] = ST_EMPTY;
            t_gen[i]   = '0;
            t_short[i] = '0;
            t_long[i]  = '0;
            t_lval[i]  = 1'b0;
            t_prev[i]  = '0;
            t_disc[i]  = '0;
            t_busy[i]  = 1'b0;
         end
         expected_rsps.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) no_addr = csr_mon.invalid_short_addr;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result transfer with nothing expected, expected none, actual %0h",
                  $time, rsp_mon.result_index);
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("found", e.found, rsp_mon.found);
               check_field("result_index", e.result_index, rsp_mon.result_index);
               check_field("result_generation", e.result_generation,
                  rsp_mon.result_generation);
               check_field("result_state", e.result_state, rsp_mon.result_state);
               check_field("result_short", e.result_short, rsp_mon.result_short);
               check_field("result_previous_short", e.result_previous_short,
                  rsp_mon.result_previous_short);
               check_field("result_long", e.result_long, rsp_mon.result_long);
               check_field("result_long_valid", e.result_long_valid,
                  rsp_mon.result_long_valid);
               check_field("outcome", e.outcome, rsp_mon.outcome);
            end
         end
         if (req_mon.valid && req_mon.ready) expected_rsps.push_back(predict_lookup());
      end
   end

   initial error_count = 0;

endmodule
`default_nettype wire

### bench/tb_device_address_table_core.sv
// Testbench top of the device address table: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_device_address_table_core;
   import dat_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   pending_count;
   logic [15:0] cur_invalid;
   bit   calm_sender;

   dat_req_if req_if();
   dat_rsp_if rsp_if();
   dat_csr_if csr_if();

   device_address_table_core #(.SLOT_COUNT(16)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   dat_table_checker #(.SLOT_COUNT(16)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("device_address_table_core verification failed");
         $finish;
      end
   end

   // The receiver stalls at random, except in a quiet window of the run.
   always @(negedge clock) begin
      if (cycle_count > 30000 && cycle_count < 50000) rsp_if.ready = 1'b1;
      else rsp_if.ready = ($urandom_range(0, 99) >= 12);
   end

   task automatic send(logic [3:0] cmd, logic [15:0] sa, logic [63:0] la, bit lp, bit any,
         logic [3:0] idx, logic [31:0] hg, bit bv);
      if (!calm_sender && $urandom_range(0, 99) < 12) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid             = 1'b1;
      req_if.command           = cmd;
      req_if.short_address     = sa;
      req_if.long_address      = la;
      req_if.long_present      = lp;
      req_if.include_inactive  = any;
      req_if.slot_index        = idx;
      req_if.handle_generation = hg;
      req_if.busy_value        = bv;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      // Let any work still in flight settle before the register moves.
      repeat (120) @(negedge clock);
   endtask

   task automatic write_invalid(logic [15:0] v);
      @(negedge clock);
      csr_if.valid              = 1'b1;
      csr_if.invalid_short_addr = v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
      cur_invalid  = v;
   endtask

   function automatic logic [15:0] pick_short(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, span));
      if (r < 82) return cur_invalid;
      return 16'($urandom);
   endfunction

   function automatic logic [63:0] pick_long();
      if ($urandom_range(0, 99) < 65) return 64'hA5C3_0000_0000_0000 | $urandom_range(0, 11);
      return {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return CMD_UPSERT;
      if (r < 44) return CMD_FIND_LONG;
      if (r < 53) return CMD_FIND_SHORT;
      if (r < 61) return CMD_CHECK;
      if (r < 69) return CMD_SET_BUSY;
      if (r < 78) return CMD_RECLAIM;
      if (r < 84) return CMD_CLAIM;
      if (r < 89) return CMD_RELEASE;
      if (r < 92) return CMD_RESET_DISC;
      if (r < 97) return CMD_ROUTE;
      return 4'(CMD_ROUTE) + 4'($urandom_range(1, 6));
   endfunction

   task automatic random_phase(int count, int span);
      logic [31:0] hg;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         calm_sender = (n >= 100 && n < 250);
         hg = ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, 40)) : $urandom;
         send(pick_cmd(), pick_short(span), pick_long(), $urandom_range(0, 1),
            $urandom_range(0, 1), 4'($urandom_range(0, 15)), hg, $urandom_range(0, 1));
      end
      calm_sender = 1'b0;
      drain();
   endtask

   initial begin
      cycle_count = 0;
      calm_sender = 1'b0;
      cur_invalid = 16'hFFFF;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_UPSERT;
      req_if.short_address = '0;
      req_if.long_address = '0;
      req_if.long_present = 1'b0;
      req_if.include_inactive = 1'b0;
      req_if.slot_index = '0;
      req_if.handle_generation = '0;
      req_if.busy_value = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.invalid_short_addr = 16'hFFFF;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_invalid(16'hFFFF);
      send(CMD_UPSERT, 16'd1, '0, 0, 0, 0, 0, 0);
      send(CMD_UPSERT, 16'd2, 64'h0123_4567_89AB_CDEF, 1, 0, 0, 0, 0);
      send(CMD_FIND_LONG, 0, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, 0);
      send(CMD_FIND_SHORT, 16'd2, '0, 0, 0, 0, 0, 0);
      send(CMD_CHECK, 0, '0, 0, 0, 4'd0, 32'd1, 0);
      send(CMD_CHECK, 0, '0, 0, 1, 4'd0, 32'hFFFF_FFFF, 0);
      send(CMD_SET_BUSY, 0, '0, 0, 0, 4'd1, 0, 1);
      // A new long address takes short address 2 and pushes the busy holder out.
      send(CMD_UPSERT, 16'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0);
      send(CMD_FIND_LONG, 0, 64'h0123_4567_89AB_CDEF, 0, 1, 0, 0, 0);
      send(CMD_CHECK, 0, '0, 0, 1, 4'd1, 32'd1, 0);
      send(CMD_RECLAIM, 0, '0, 0, 0, 4'd1, 0, 0);
      send(CMD_SET_BUSY, 0, '0, 0, 0, 4'd1, 0, 0);
      send(CMD_RECLAIM, 0, '0, 0, 0, 4'd1, 0, 0);
      send(CMD_CLAIM, 0, '0, 0, 0, 4'd0, 0, 0);
      send(CMD_CLAIM, 0, '0, 0, 0, 4'd0, 0, 0);
      send(CMD_RELEASE, 16'd1, '0, 0, 0, 4'd0, 0, 0);
      send(CMD_RESET_DISC, 0, '0, 0, 0, 4'd0, 0, 0);
      send(CMD_ROUTE, 16'd1, '0, 0, 0, 4'd0, 0, 0);
      send(CMD_ROUTE, 16'hFFFF, '0, 0, 0, 4'd0, 0, 0);
      send(4'(CMD_ROUTE) + 4'd6, 16'hFFFF, '1, 1, 1, 4'd15, '1, 1);
      send(CMD_UPSERT, 16'hFFFF, '0, 0, 0, 0, 0, 0);
      send(CMD_SET_BUSY, 0, '0, 0, 0, 4'd15, 0, 1);
      send(CMD_UPSERT, 16'd0, '0, 1, 0, 0, 0, 0);
      send(CMD_FIND_SHORT, 16'd7, '0, 0, 1, 0, 0, 0);
      drain();

      random_phase(700, 23);
      write_invalid(16'h0000);
      random_phase(650, 12);
      write_invalid(16'($urandom_range(1, 20)));
      // A wide address spread fills the table.
      random_phase(650, 60);

      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (error_count == 0) begin
         $display("device_address_table_core verification clean");
      end else begin
         $display("device_address_table_core verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
